[rtl/lps_pkg.sv]
package lps_pkg;

    localparam int unsigned N_LNG = 12;
    localparam int unsigned N_LAT = 5;
    localparam int unsigned COEF_BITS = 25;
    localparam int unsigned ANGLE_BITS = 32;
    localparam int unsigned IN_BITS = 7 * ANGLE_BITS;
    localparam int unsigned OUT_BITS = 2 * ANGLE_BITS;

    localparam logic REG_ENABLE = 1'b0;

    // Coefficients in binary-angle units (degrees / 360 * 2^32, rounded)
    localparam logic signed [COEF_BITS-1:0] LNG_COEF [N_LNG] = '{
        -25'sd15199412, 25'sd7850246, -25'sd2219066, -25'sd703897,
        -25'sd680036, 25'sd632315, 25'sd548801, 25'sd489149,
        -25'sd417566, -25'sd369844, -25'sd178957, 25'sd131235
    };
    localparam logic signed [COEF_BITS-1:0] LAT_COEF [N_LAT] = '{
        -25'sd2063970, -25'sd656176, -25'sd548801, 25'sd393705, -25'sd202818
    };

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    function automatic longint unsigned taylor_div(input int k);
        case (k)
            1: taylor_div = 64'd6;
            2: taylor_div = 64'd20;
            3: taylor_div = 64'd42;
            4: taylor_div = 64'd72;
            5: taylor_div = 64'd110;
            6: taylor_div = 64'd156;
            7: taylor_div = 64'd210;
            default: taylor_div = 64'd272;
        endcase
    endfunction

    // Truncating quotient by shift and subtract; used only while building the table
    function automatic longint unsigned table_quot(input longint unsigned n,
                                                   input longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], n[b]};
            q = {q[62:0], 1'b0};
            if (rem >= d) begin
                rem = rem - d;
                q[0] = 1'b1;
            end
        end
        table_quot = q;
    endfunction

    // Sine of a Q30 radian angle by an eight-step Taylor series, clamped to [0, 1]
    function automatic longint unsigned sin_q30(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint sum;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            term = table_quot((term * x2) >> 30, taylor_div(k));
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
        sin_q30 = longint'(sum);
    endfunction

    function automatic longint unsigned sine_entry(input int i, input int tb, input int vb);
        longint unsigned x;
        longint unsigned s;
        longint unsigned v;
        longint unsigned cap;
        cap = (64'd1 << (vb - 1)) - 64'd1;
        x = (longint'(i) * HALF_PI_Q30 + ((64'd1 << tb) >> 1)) >> tb;
        s = sin_q30(x);
        v = (s * (64'd1 << (vb - 1)) + (64'd1 << 29)) >> 30;
        if (v > cap) v = cap;
        sine_entry = v;
    endfunction

endpackage

[rtl/lps_sine_rom.sv]
module lps_sine_rom #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int SINE_VALUE_BITS = 18
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [lps_pkg::ANGLE_BITS-1:0]    i_angle,
    output logic signed [SINE_VALUE_BITS-1:0] o_sine
);
    import lps_pkg::*;

    localparam int QTR = 1 << SINE_TABLE_BITS;

    logic [SINE_VALUE_BITS-2:0] w_rom [QTR+1];
    logic [1:0]                 w_quad;
    logic [SINE_TABLE_BITS:0]   w_pos;
    logic [SINE_TABLE_BITS:0]   w_idx;
    logic [SINE_VALUE_BITS-2:0] r_mag;
    logic                       r_neg;
    logic signed [SINE_VALUE_BITS-1:0] w_mag_s;

    for (genvar g = 0; g <= QTR; g++) begin : g_tab
        localparam longint unsigned ENTRY = sine_entry(g, SINE_TABLE_BITS, SINE_VALUE_BITS);
        assign w_rom[g] = ENTRY[SINE_VALUE_BITS-2:0];
    end

    assign w_quad = i_angle[31:30];
    assign w_pos  = {1'b0, i_angle[29 -: SINE_TABLE_BITS]};
    // mirror the index in the second and fourth quadrants
    assign w_idx  = w_quad[0] ? ((SINE_TABLE_BITS+1)'(QTR) - w_pos) : w_pos;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= w_rom[w_idx];
            r_neg <= w_quad[1];
        end
    end

    assign w_mag_s = $signed({1'b0, r_mag});
    assign o_sine  = r_neg ? -w_mag_s : w_mag_s;

endmodule

[rtl/lps_accum.sv]
module lps_accum #(
    parameter int SINE_VALUE_BITS = 18
) (
    input  logic                                        i_clk,
    input  logic                                        i_en,
    input  logic [lps_pkg::N_LNG-1:0][SINE_VALUE_BITS-1:0] i_lng_sine,
    input  logic [lps_pkg::N_LAT-1:0][SINE_VALUE_BITS-1:0] i_lat_sine,
    output logic [lps_pkg::ANGLE_BITS-1:0]              o_lng_corr,
    output logic [lps_pkg::ANGLE_BITS-1:0]              o_lat_corr
);
    import lps_pkg::*;

    localparam int PW = COEF_BITS + SINE_VALUE_BITS;
    localparam int SW = SINE_VALUE_BITS + ANGLE_BITS + 1;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (SINE_VALUE_BITS - 2);

    logic signed [PW-1:0] r_lng_prod [N_LNG];
    logic signed [PW-1:0] r_lat_prod [N_LAT];
    logic signed [SW-1:0] r_lng_part [4];
    logic signed [SW-1:0] r_lat_part [2];
    logic signed [SW-1:0] w_lng_sum;
    logic signed [SW-1:0] w_lat_sum;

    // multiply each term by its coefficient
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N_LNG; i++)
                r_lng_prod[i] <= PW'(LNG_COEF[i]) * PW'($signed(i_lng_sine[i]));
            for (int i = 0; i < N_LAT; i++)
                r_lat_prod[i] <= PW'(LAT_COEF[i]) * PW'($signed(i_lat_sine[i]));
        end
    end

    // partial sums in groups of three (the last latitude group holds two)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int g = 0; g < 4; g++)
                r_lng_part[g] <= SW'(r_lng_prod[3*g]) + SW'(r_lng_prod[3*g+1])
                    + SW'(r_lng_prod[3*g+2]);
            r_lat_part[0] <= SW'(r_lat_prod[0]) + SW'(r_lat_prod[1]) + SW'(r_lat_prod[2]);
            r_lat_part[1] <= SW'(r_lat_prod[3]) + SW'(r_lat_prod[4]);
        end
    end

    assign w_lng_sum = r_lng_part[0] + r_lng_part[1] + r_lng_part[2] + r_lng_part[3] + HALF;
    assign w_lat_sum = r_lat_part[0] + r_lat_part[1] + HALF;

    // rescale, rounding half upward
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_lng_corr <= w_lng_sum[SINE_VALUE_BITS-1 +: ANGLE_BITS];
            o_lat_corr <= w_lat_sum[SINE_VALUE_BITS-1 +: ANGLE_BITS];
        end
    end

endmodule

[rtl/lunar_perturbation_series.sv]
// Channel   Direction  Payload
// s_axis    in         mm, Lm, N, Ms, Ls, lng_in, lat_in (32 bits each)
// m_axis    out        lng_out, lat_out (32 bits each)
// apb       in/out     perturb_enable at byte address 0
//
// Six register stages: angles, sine lookup, products, partial sums, rescale,
// output. One item per cycle while the output is not stalled.
// Reset clears the valid bits and sets perturb_enable.
// A stall at the output freezes every stage together, so nothing is lost.
module lunar_perturbation_series #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int SINE_VALUE_BITS = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // mm, Lm, N, Ms, Ls, lng_in, lat_in from bit 0 up
    input  logic [lps_pkg::IN_BITS-1:0]         s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // lng_out, lat_out from bit 0 up
    output logic [lps_pkg::OUT_BITS-1:0]        m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import lps_pkg::*;

    localparam int DEPTH = 6;

    logic                  r_enable;
    logic [DEPTH-1:0]      r_valid;
    logic                  w_adv;

    logic [31:0] w_mm, w_lm, w_nd, w_ms, w_ls;
    logic [31:0] w_d, w_f, w_d2;
    logic [N_LNG-1:0][31:0] n_lng_ang, r_lng_ang;
    logic [N_LAT-1:0][31:0] n_lat_ang, r_lat_ang;
    logic [N_LNG-1:0][SINE_VALUE_BITS-1:0] w_lng_sine;
    logic [N_LAT-1:0][SINE_VALUE_BITS-1:0] w_lat_sine;
    logic [31:0] w_lng_corr, w_lat_corr;
    logic [DEPTH-2:0][31:0] r_lng_d, r_lat_d;
    logic [31:0] r_lng_out, r_lat_out;

    // configuration port
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (psel && penable && pwrite && paddr[2] == REG_ENABLE) begin
            r_enable <= pwdata[0];
        end
    end
    assign prdata = (paddr[2] == REG_ENABLE) ? {31'b0, r_enable} : 32'b0;

    // advance all stages together unless the output item is held
    assign w_adv         = !r_valid[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_valid[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_adv) begin
            r_valid <= {r_valid[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // stage 1: form D, F and every term argument
    assign w_mm = s_axis_tdata[31:0];
    assign w_lm = s_axis_tdata[63:32];
    assign w_nd = s_axis_tdata[95:64];
    assign w_ms = s_axis_tdata[127:96];
    assign w_ls = s_axis_tdata[159:128];
    assign w_d  = w_lm - w_ls;
    assign w_f  = w_lm - w_nd;
    assign w_d2 = {w_d[30:0], 1'b0};

    always_comb begin
        n_lng_ang[0]  = w_mm - w_d2;
        n_lng_ang[1]  = w_d2;
        n_lng_ang[2]  = w_ms;
        n_lng_ang[3]  = {w_mm[30:0], 1'b0} - w_d2;
        n_lng_ang[4]  = w_mm - w_d2 + w_ms;
        n_lng_ang[5]  = w_mm + w_d2;
        n_lng_ang[6]  = w_d2 - w_ms;
        n_lng_ang[7]  = w_mm - w_ms;
        n_lng_ang[8]  = w_d;
        n_lng_ang[9]  = w_mm + w_ms;
        n_lng_ang[10] = {w_f[30:0], 1'b0} - w_d2;
        n_lng_ang[11] = w_mm - {w_d[29:0], 2'b0};
        n_lat_ang[0]  = w_f - w_d2;
        n_lat_ang[1]  = w_mm - w_f - w_d2;
        n_lat_ang[2]  = w_mm + w_f - w_d2;
        n_lat_ang[3]  = w_f + w_d2;
        n_lat_ang[4]  = {w_mm[30:0], 1'b0} + w_f;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lng_ang <= n_lng_ang;
            r_lat_ang <= n_lat_ang;
            r_lng_d   <= {r_lng_d[DEPTH-3:0], s_axis_tdata[191:160]};
            r_lat_d   <= {r_lat_d[DEPTH-3:0], s_axis_tdata[223:192]};
        end
    end

    // stage 2: sine lookups
    for (genvar i = 0; i < N_LNG; i++) begin : g_lng_sin
        lps_sine_rom #(
            .SINE_TABLE_BITS(SINE_TABLE_BITS),
            .SINE_VALUE_BITS(SINE_VALUE_BITS)
        ) u_rom (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_angle(r_lng_ang[i]),
            .o_sine (w_lng_sine[i])
        );
    end
    for (genvar i = 0; i < N_LAT; i++) begin : g_lat_sin
        lps_sine_rom #(
            .SINE_TABLE_BITS(SINE_TABLE_BITS),
            .SINE_VALUE_BITS(SINE_VALUE_BITS)
        ) u_rom (
            .i_clk  (i_clk),
            .i_en   (w_adv),
            .i_angle(r_lat_ang[i]),
            .o_sine (w_lat_sine[i])
        );
    end

    // stages 3 to 5: products, partial sums, rescale
    lps_accum #(
        .SINE_VALUE_BITS(SINE_VALUE_BITS)
    ) u_accum (
        .i_clk     (i_clk),
        .i_en      (w_adv),
        .i_lng_sine(w_lng_sine),
        .i_lat_sine(w_lat_sine),
        .o_lng_corr(w_lng_corr),
        .o_lat_corr(w_lat_corr)
    );

    // stage 6: apply corrections, or pass through when disabled
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lng_out <= r_enable ? r_lng_d[DEPTH-2] + w_lng_corr : r_lng_d[DEPTH-2];
            r_lat_out <= r_enable ? r_lat_d[DEPTH-2] + w_lat_corr : r_lat_d[DEPTH-2];
        end
    end

    assign m_axis_tdata = {r_lat_out, r_lng_out};

endmodule

[tb/sv/lunar_perturbation_series_tb.sv]
`timescale 1ns / 1ps

module lunar_perturbation_series_tb;
    import lps_pkg::*;

    localparam int TAB_BITS = 10;
    localparam int VAL_BITS = 18;
    localparam int QTR = 1 << TAB_BITS;
    localparam int PIPE_DEPTH = 6;
    localparam logic [2:0] ADDR_ENABLE = 3'd0;

    typedef struct packed {
        logic [31:0] lat_in;
        logic [31:0] lng_in;
        logic [31:0] ls;
        logic [31:0] ms;
        logic [31:0] nd;
        logic [31:0] lm;
        logic [31:0] mm;
    } orbit_item_t;

    typedef struct packed {
        logic [31:0] lat_out;
        logic [31:0] lng_out;
    } corrected_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // mm, Lm, N, Ms, Ls, lng_in, lat_in from bit 0 up
    logic [IN_BITS-1:0]  s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // lng_out, lat_out from bit 0 up
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [2:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    lunar_perturbation_series #(
        .SINE_TABLE_BITS(TAB_BITS),
        .SINE_VALUE_BITS(VAL_BITS)
    ) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state
    int          sine_lut [QTR+1];
    logic        corr_on = 1'b1;
    corrected_t  pending_q [$];
    int          n_fail = 0;
    int          n_sent = 0;
    int          n_checked = 0;
    int          n_bypass = 0;
    bit          rx_hold = 1'b0;   // long receiver hold-off
    bit          quiet = 1'b0;     // no idling in the closing stretch

    // Build the quarter-wave table with the same integer steps as the block's spec
    function automatic longint unsigned taylor_sine(longint unsigned x);
        longint unsigned x2, term;
        longint acc;
        x2 = (x * x) >> 30;
        term = x;
        acc = longint'(x);
        for (int k = 1; k <= 8; k++) begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k & 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
        return longint'(acc);
    endfunction

    function automatic void fill_sine_lut();
        longint unsigned x, s, v, cap;
        cap = (64'd1 << (VAL_BITS - 1)) - 1;
        for (int i = 0; i <= QTR; i++) begin
            x = (longint'(i) * 64'd1686629713 + (QTR >> 1)) >> TAB_BITS;
            s = taylor_sine(x);
            v = (s * (64'd1 << (VAL_BITS - 1)) + (64'd1 << 29)) >> 30;
            if (v > cap) v = cap;
            sine_lut[i] = int'(v);
        end
    endfunction

    function automatic longint lut_sine(logic [31:0] a);
        logic [1:0] quad;
        int pos, idx;
        longint v;
        quad = a[31:30];
        pos = int'(a[29 -: TAB_BITS]);
        idx = quad[0] ? QTR - pos : pos;
        v = sine_lut[idx];
        return quad[1] ? -v : v;
    endfunction

    // Divide by 2^(VAL_BITS-1), rounding half upwards; keep low 32 bits
    function automatic logic [31:0] rescale(longint acc);
        longint r;
        r = (acc + (64'sd1 <<< (VAL_BITS - 2))) >>> (VAL_BITS - 1);
        return r[31:0];
    endfunction

    function automatic corrected_t correct_position(orbit_item_t it);
        logic [31:0] d, f, d2, mm, ms;
        logic [31:0] la [12];
        logic [31:0] lb [5];
        longint sl, sb;
        corrected_t res;
        res.lng_out = it.lng_in;
        res.lat_out = it.lat_in;
        if (!corr_on) return res;
        mm = it.mm;
        ms = it.ms;
        d = it.lm - it.ls;
        f = it.lm - it.nd;
        d2 = d << 1;
        la = '{mm - d2, d2, ms, (mm << 1) - d2, mm - d2 + ms, mm + d2, d2 - ms,
               mm - ms, d, mm + ms, (f << 1) - d2, mm - (d << 2)};
        lb = '{f - d2, mm - f - d2, mm + f - d2, f + d2, (mm << 1) + f};
        sl = 0;
        sb = 0;
        for (int i = 0; i < 12; i++) sl += longint'(LNG_COEF[i]) * lut_sine(la[i]);
        for (int i = 0; i < 5; i++) sb += longint'(LAT_COEF[i]) * lut_sine(lb[i]);
        res.lng_out = it.lng_in + rescale(sl);
        res.lat_out = it.lat_in + rescale(sb);
        return res;
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(orbit_item_t it);
        s_axis_tdata <= it;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_q.push_back(correct_position(it));
        n_sent++;
        if (!corr_on) n_bypass++;
    endtask

    task automatic rest_sender();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_enable(logic val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_ENABLE; pwdata <= {31'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        corr_on = val;
        @(posedge i_clk);
    endtask

    function automatic orbit_item_t random_item();
        orbit_item_t it;
        it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        // Pull angles onto quadrant edges now and then
        if ($urandom_range(0, 7) == 0) it.mm = {2'($urandom_range(0, 3)), 30'd0};
        if ($urandom_range(0, 7) == 0) it.lm = it.ls;
        if ($urandom_range(0, 7) == 0) it.lng_in = 32'h7fff_ffff;
        if ($urandom_range(0, 7) == 0) it.lat_in = 32'h8000_0000;
        return it;
    endfunction

    // Directed table: expected value typed only for the pass-through rows
    typedef struct {
        logic        en;
        orbit_item_t it;
        bit          typed;
        corrected_t  want;
    } row_t;

    row_t rows [] = '{
        '{1'b1, '0, 1'b0, '0},
        '{1'b1, '1, 1'b0, '0},
        '{1'b1, {32'h8000_0000, 32'h7fff_ffff, 32'h4000_0000, 32'hc000_0000,
                 32'h0, 32'h4000_0000, 32'h8000_0000}, 1'b0, '0},
        '{1'b1, {32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0,
                 32'hffff_ffff, 32'h0, 32'h1}, 1'b0, '0},
        '{1'b1, {32'h1234_5678, 32'h9abc_def0, 32'h0, 32'h0,
                 32'h4000_0000, 32'h4000_0000, 32'h4000_0000}, 1'b0, '0},
        '{1'b1, {32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa}, 1'b0, '0},
        '{1'b0, '0, 1'b1, '0},
        '{1'b0, '1, 1'b1, '1},
        '{1'b0, {32'h8000_0000, 32'h7fff_ffff, {5{32'h1357_9bdf}}}, 1'b1,
                 {32'h8000_0000, 32'h7fff_ffff}},
        '{1'b0, {32'h5555_5555, 32'haaaa_aaaa, {5{32'hffff_ffff}}}, 1'b1,
                 {32'h5555_5555, 32'haaaa_aaaa}}
    };

    // Receiver: random back-pressure, with one long hold-off on request
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (40) @(posedge i_clk);
                rx_hold = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Checker: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            corrected_t got, want;
            got = m_axis_tdata;
            if (pending_q.size() == 0) begin
                $error("unexpected result lng_out=%h lat_out=%h", got.lng_out, got.lat_out);
                n_fail++;
            end else begin
                want = pending_q.pop_front();
                if (got.lng_out !== want.lng_out) begin
                    $error("lng_out expected %h actual %h", want.lng_out, got.lng_out);
                    n_fail++;
                end
                if (got.lat_out !== want.lat_out) begin
                    $error("lat_out expected %h actual %h", want.lat_out, got.lat_out);
                    n_fail++;
                end
                n_checked++;
            end
        end
    end

    // Main sequence
    initial begin
        corrected_t typed_want;
        fill_sine_lut();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows; switch the register only when the pipe is empty
        foreach (rows[r]) begin
            if (rows[r].en != corr_on) begin
                drain();
                write_enable(rows[r].en);
            end
            if (rows[r].typed) begin
                typed_want = correct_position(rows[r].it);
                if (typed_want !== rows[r].want) begin
                    $error("pass-through row %0d expected %h actual %h",
                           r, rows[r].want, typed_want);
                    n_fail++;
                end
            end
            send_item(rows[r].it);
        end
        drain();
        write_enable(1'b1);

        // Fill the pipe while the receiver holds off
        rx_hold = 1'b1;
        for (int i = 0; i < 30; i++) send_item(random_item());

        // Random phases, every third one with corrections off; the sender pauses for empty between them
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_enable(ph % 3 != 2);
            for (int i = 0; i < 80; i++) begin
                send_item(random_item());
                rest_sender();
            end
        end

        // Closing stretch with no idling on either side
        quiet = 1'b1;
        for (int i = 0; i < 40; i++) send_item(random_item());
        drain();

        $display("Sent %0d items (%0d with corrections off), checked %0d results;",
                 n_sent, n_bypass, n_checked);
        $display("covered pipeline fill under a long output stall and both enable settings.");
        if (n_fail == 0 && pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
